@@ hdl/mrsi_pkg.sv @@
// ----------------------------------------------------------------------------
// mrsi_pkg
// Shared types and constants for the strictly-increasing replacement solver.
// ----------------------------------------------------------------------------
`default_nettype none

package mrsi_pkg;

   localparam int FIRST_DEPTH_DEF = 64;
   localparam int POOL_DEPTH_DEF  = 64;
   localparam int VALUE_W         = 31;
   localparam int ROW_W           = 32;
   localparam int MIN_OPS_W       = 7;
   localparam int ACTION_W        = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_FIRST = 2'd0,
      ACT_LOAD_POOL  = 2'd1,
      ACT_START      = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   // controller -> datapath strobes
   typedef struct packed {
      logic first_wr;
      logic first_rd;
      logic pool_ld;
      logic pool_rd;
      logic sort_wr;
      logic sort_sel_v;
      logic take_v;
      logic take_own;
      logic row_init;
      logic row_rd;
      logic row_wr;
      logic take_last;
      logic carry_clr;
      logic carry_take;
      logic bank_flip;
   } cmd_type;

   // datapath -> controller flags
   typedef struct packed {
      logic sort_gt;
      logic bs_le;
      logic row_valid;
      logic scan_hit;
   } stat_type;

endpackage

`default_nettype wire

@@ hdl/mrsi_dp.sv @@
// ----------------------------------------------------------------------------
// mrsi_dp
// Datapath: array and pool memories, two DP row banks with valid bits,
// comparators and the working registers of the sort, search and row update.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsi_dp #(
   parameter int FIRST_DEPTH = mrsi_pkg::FIRST_DEPTH_DEF,
   parameter int POOL_DEPTH  = mrsi_pkg::POOL_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mrsi_pkg::cmd_type             cmd,
   output      mrsi_pkg::stat_type            stat,
   input  wire logic [mrsi_pkg::VALUE_W-1:0]  load_value,
   input  wire logic [((FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1)-1:0] first_addr,
   input  wire logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0]   pool_waddr,
   input  wire logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0]   pool_raddr,
   input  wire logic [$clog2(POOL_DEPTH+1)-1:0]                         row_addr
);

   localparam int ROWS = POOL_DEPTH + 1;
   localparam int VW   = mrsi_pkg::VALUE_W;
   localparam int RW   = mrsi_pkg::ROW_W;

   logic [VW-1:0] first_mem [FIRST_DEPTH];
   logic [VW-1:0] pool_mem  [POOL_DEPTH];
   logic [RW-1:0] row0_mem  [ROWS];
   logic [RW-1:0] row1_mem  [ROWS];
   logic [ROWS-1:0] vld0_ff;
   logic [ROWS-1:0] vld1_ff;

   logic [VW-1:0] first_rd_ff;
   logic [VW-1:0] pool_rd_ff;
   logic [RW-1:0] row_rd_ff;
   logic          row_vld_rd_ff;
   logic [VW-1:0] v_ff;
   logic [VW-1:0] own_ff;
   logic [RW-1:0] last_ff;
   logic [VW-1:0] carry_ff;
   logic          carry_ok_ff;
   logic          bank_ff;

   logic          keep_ok;
   logic          use_carry;
   logic [RW-1:0] nv_val;
   logic          nv_ok;

   // keep own value if it exceeds the previous last element
   assign keep_ok   = row_vld_rd_ff && ($signed({1'b0, own_ff}) > $signed(row_rd_ff));
   assign use_carry = carry_ok_ff && (!keep_ok || (carry_ff < own_ff));
   assign nv_val    = use_carry ? {1'b0, carry_ff} : {1'b0, own_ff};
   assign nv_ok     = keep_ok || carry_ok_ff;

   assign stat.sort_gt   = pool_rd_ff > v_ff;
   assign stat.bs_le     = $signed({1'b0, pool_rd_ff}) <= $signed(last_ff);
   assign stat.row_valid = row_vld_rd_ff;
   assign stat.scan_hit  = bank_ff ? vld1_ff[row_addr] : vld0_ff[row_addr];

   always_ff @(posedge clock) begin
      if (cmd.first_wr) begin
         first_mem[first_addr] <= load_value;
      end
      if (cmd.first_rd) begin
         first_rd_ff <= first_mem[first_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pool_ld) begin
         pool_mem[pool_waddr] <= load_value;
      end else if (cmd.sort_wr) begin
         pool_mem[pool_waddr] <= cmd.sort_sel_v ? v_ff : pool_rd_ff;
      end
      if (cmd.pool_rd) begin
         pool_rd_ff <= pool_mem[pool_raddr];
      end
   end

   // bank_ff selects the previous row; the next row goes to the other bank
   always_ff @(posedge clock) begin
      if (cmd.row_init && !bank_ff) begin
         row0_mem[0] <= '1;
      end else if (cmd.row_wr && bank_ff) begin
         row0_mem[row_addr] <= nv_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_init && bank_ff) begin
         row1_mem[0] <= '1;
      end else if (cmd.row_wr && !bank_ff) begin
         row1_mem[row_addr] <= nv_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_rd) begin
         row_rd_ff     <= bank_ff ? row1_mem[row_addr] : row0_mem[row_addr];
         row_vld_rd_ff <= bank_ff ? vld1_ff[row_addr] : vld0_ff[row_addr];
      end
      if (cmd.take_v) begin
         v_ff <= pool_rd_ff;
      end
      if (cmd.take_own) begin
         own_ff <= first_rd_ff;
      end
      if (cmd.take_last) begin
         last_ff <= row_rd_ff;
      end
      if (cmd.carry_take) begin
         carry_ff <= pool_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff     <= '0;
         vld1_ff     <= '0;
         carry_ok_ff <= 1'b0;
         bank_ff     <= 1'b0;
      end else begin
         if (cmd.row_init) begin
            if (bank_ff) begin
               vld1_ff <= ROWS'(1);
            end else begin
               vld0_ff <= ROWS'(1);
            end
         end else if (cmd.row_wr) begin
            if (bank_ff) begin
               vld0_ff[row_addr] <= nv_ok;
            end else begin
               vld1_ff[row_addr] <= nv_ok;
            end
         end
         if (cmd.carry_take) begin
            carry_ok_ff <= 1'b1;
         end else if (cmd.carry_clr) begin
            carry_ok_ff <= 1'b0;
         end
         if (cmd.bank_flip) begin
            bank_ff <= !bank_ff;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/mrsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrsi_ctrl
// Controller: load counters, insertion sort, row sweep with binary search,
// final scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsi_ctrl #(
   parameter int FIRST_DEPTH = mrsi_pkg::FIRST_DEPTH_DEF,
   parameter int POOL_DEPTH  = mrsi_pkg::POOL_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [mrsi_pkg::ACTION_W-1:0]  req_action,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [mrsi_pkg::MIN_OPS_W-1:0] rsp_min_ops,
   output      logic                           rsp_impossible,
   output      logic                           rsp_overflow,
   output      mrsi_pkg::cmd_type              cmd,
   input  wire mrsi_pkg::stat_type             stat,
   output      logic [((FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1)-1:0] first_addr,
   output      logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0]   pool_waddr,
   output      logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0]   pool_raddr,
   output      logic [$clog2(POOL_DEPTH+1)-1:0]                         row_addr
);

   localparam int FAW = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int FCW = $clog2(FIRST_DEPTH + 1);
   localparam int PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int PCW = $clog2(POOL_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SORT_I, S_SORT_V, S_SORT_RD, S_SORT_CMP, S_ROW, S_OWN, S_JRD,
      S_JGOT, S_BS, S_BSCMP, S_BSVAL, S_JNEXT, S_SCAN, S_OUT
   } state_type;

   state_type      state_ff;
   logic [FCW-1:0] fcnt_ff;
   logic [PCW-1:0] pcnt_ff;
   logic           drop_ff;
   logic [PCW-1:0] si_ff;
   logic [PCW-1:0] k_ff;
   logic [FCW-1:0] i_ff;
   logic [PCW-1:0] j_ff;
   logic [PCW-1:0] lo_ff;
   logic [PCW-1:0] hi_ff;
   logic [PCW-1:0] mid_ff;
   logic           rsp_valid_ff;
   logic [mrsi_pkg::MIN_OPS_W-1:0] min_ops_ff;
   logic           imp_ff;
   logic           ovf_ff;

   logic           acc;
   logic [PCW:0]   mid_sum;
   logic [PCW-1:0] mid_c;
   logic [PCW-1:0] k_dec;

   assign req_tready     = (state_ff == S_IDLE);
   assign acc            = req_tvalid && req_tready;
   assign mid_sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c          = mid_sum[PCW:1];
   assign k_dec          = k_ff - PCW'(1);
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_min_ops    = min_ops_ff;
   assign rsp_impossible = imp_ff;
   assign rsp_overflow   = ovf_ff;
   assign row_addr       = j_ff;
   assign first_addr     = (state_ff == S_IDLE) ? fcnt_ff[FAW-1:0] : i_ff[FAW-1:0];
   assign pool_waddr     = (state_ff == S_IDLE) ? pcnt_ff[PAW-1:0] : k_ff[PAW-1:0];

   always_comb begin
      case (state_ff)
         S_SORT_I:  pool_raddr = si_ff[PAW-1:0];
         S_SORT_RD: pool_raddr = k_dec[PAW-1:0];
         S_BS:      pool_raddr = (lo_ff < hi_ff) ? mid_c[PAW-1:0] : lo_ff[PAW-1:0];
         default:   pool_raddr = mid_c[PAW-1:0];
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.first_wr = acc && (req_action == mrsi_pkg::ACT_LOAD_FIRST)
                           && (fcnt_ff < FCW'(FIRST_DEPTH));
            cmd.pool_ld  = acc && (req_action == mrsi_pkg::ACT_LOAD_POOL)
                           && (pcnt_ff < PCW'(POOL_DEPTH));
            cmd.row_init = acc && (req_action == mrsi_pkg::ACT_START);
         end
         S_SORT_I:   cmd.pool_rd = (si_ff < pcnt_ff);
         S_SORT_V:   cmd.take_v = 1'b1;
         S_SORT_RD: begin
            cmd.sort_wr    = (k_ff == '0);
            cmd.sort_sel_v = 1'b1;
            cmd.pool_rd    = (k_ff != '0);
         end
         S_SORT_CMP: begin
            cmd.sort_wr    = 1'b1;
            cmd.sort_sel_v = !stat.sort_gt;
         end
         S_ROW: begin
            cmd.first_rd  = (i_ff < fcnt_ff);
            cmd.carry_clr = 1'b1;
         end
         S_OWN:  cmd.take_own = 1'b1;
         S_JRD:  cmd.row_rd = 1'b1;
         S_JGOT: begin
            cmd.take_last = 1'b1;
            cmd.row_wr    = 1'b1;
            cmd.carry_clr = 1'b1;
         end
         S_BS:    cmd.pool_rd = (lo_ff < hi_ff) || (lo_ff < pcnt_ff);
         S_BSVAL: cmd.carry_take = 1'b1;
         S_JNEXT: cmd.bank_flip = (j_ff == pcnt_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fcnt_ff      <= '0;
         pcnt_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         si_ff        <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         mid_ff       <= '0;
         min_ops_ff   <= '0;
         imp_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  case (req_action)
                     mrsi_pkg::ACT_LOAD_FIRST: begin
                        if (fcnt_ff < FCW'(FIRST_DEPTH)) begin
                           fcnt_ff <= fcnt_ff + FCW'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     mrsi_pkg::ACT_LOAD_POOL: begin
                        if (pcnt_ff < PCW'(POOL_DEPTH)) begin
                           pcnt_ff <= pcnt_ff + PCW'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     mrsi_pkg::ACT_START: begin
                        si_ff    <= PCW'(1);
                        state_ff <= S_SORT_I;
                     end
                     default: ;
                  endcase
               end
            end
            S_SORT_I: begin
               if (si_ff < pcnt_ff) begin
                  k_ff     <= si_ff;
                  state_ff <= S_SORT_V;
               end else begin
                  i_ff     <= '0;
                  state_ff <= S_ROW;
               end
            end
            S_SORT_V: state_ff <= S_SORT_RD;
            S_SORT_RD: begin
               if (k_ff == '0) begin
                  si_ff    <= si_ff + PCW'(1);
                  state_ff <= S_SORT_I;
               end else begin
                  state_ff <= S_SORT_CMP;
               end
            end
            S_SORT_CMP: begin
               if (stat.sort_gt) begin
                  k_ff     <= k_dec;
                  state_ff <= S_SORT_RD;
               end else begin
                  si_ff    <= si_ff + PCW'(1);
                  state_ff <= S_SORT_I;
               end
            end
            S_ROW: begin
               j_ff     <= '0;
               state_ff <= (i_ff < fcnt_ff) ? S_OWN : S_SCAN;
            end
            S_OWN: state_ff <= S_JRD;
            S_JRD: state_ff <= S_JGOT;
            S_JGOT: begin
               if (stat.row_valid && (j_ff < pcnt_ff)) begin
                  lo_ff    <= '0;
                  hi_ff    <= pcnt_ff;
                  state_ff <= S_BS;
               end else begin
                  state_ff <= S_JNEXT;
               end
            end
            S_BS: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_c;
                  state_ff <= S_BSCMP;
               end else if (lo_ff < pcnt_ff) begin
                  state_ff <= S_BSVAL;
               end else begin
                  state_ff <= S_JNEXT;
               end
            end
            S_BSCMP: begin
               if (stat.bs_le) begin
                  lo_ff <= mid_ff + PCW'(1);
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= S_BS;
            end
            S_BSVAL: state_ff <= S_JNEXT;
            S_JNEXT: begin
               if (j_ff == pcnt_ff) begin
                  i_ff     <= i_ff + FCW'(1);
                  state_ff <= S_ROW;
               end else begin
                  j_ff     <= j_ff + PCW'(1);
                  state_ff <= S_JRD;
               end
            end
            S_SCAN: begin
               if (stat.scan_hit) begin
                  min_ops_ff   <= mrsi_pkg::MIN_OPS_W'(j_ff);
                  imp_ff       <= 1'b0;
                  ovf_ff       <= drop_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else if (j_ff == pcnt_ff) begin
                  min_ops_ff   <= '0;
                  imp_ff       <= 1'b1;
                  ovf_ff       <= drop_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  j_ff <= j_ff + PCW'(1);
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  fcnt_ff      <= '0;
                  pcnt_ff      <= '0;
                  drop_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_imp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_impossible) |-> (rsp_min_ops == '0))
      else $error("impossible result with nonzero count");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_bs_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BS) |-> ((lo_ff <= hi_ff) && (hi_ff <= pcnt_ff)))
      else $error("binary search bounds out of order");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JGOT) |-> (j_ff <= pcnt_ff))
      else $error("row column beyond pool count");

   a_sort_k: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SORT_CMP) |-> ((k_ff != '0) && (k_ff <= si_ff)))
      else $error("insertion index out of range");

endmodule

`default_nettype wire

@@ hdl/min_replacements_strictly_increasing.sv @@
// ----------------------------------------------------------------------------
// min_replacements_strictly_increasing
// Least replacements from a value pool that make an array strictly increasing.
// ----------------------------------------------------------------------------
// Load beats (action 0 into the array, 1 into the pool) fill the two stores;
// loads into a full store are dropped and reported in the overflow flag. A
// start beat sorts the pool in place (insertion sort on the single pool read
// port), then sweeps the DP row for each of the n array values: for each
// column it reads the previous row entry and, when a search runs, does a
// binary search over the pool and fetches the first larger pool value. It
// then scans the final row for the first valid column. One result beat is
// returned per start; no input is taken until it has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module min_replacements_strictly_increasing #(
   parameter int FIRST_DEPTH = mrsi_pkg::FIRST_DEPTH_DEF,
   parameter int POOL_DEPTH  = mrsi_pkg::POOL_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // [30:0] value
   input  wire logic [1:0]  req_tuser,  // [1:0] action
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,  // [6:0] min_ops
   output      logic [1:0]  rsp_tuser   // [0] impossible, [1] overflow
);

   localparam int FAW = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int PCW = $clog2(POOL_DEPTH + 1);

   mrsi_pkg::cmd_type  cmd;
   mrsi_pkg::stat_type stat;
   logic [FAW-1:0] first_addr;
   logic [PAW-1:0] pool_waddr;
   logic [PAW-1:0] pool_raddr;
   logic [PCW-1:0] row_addr;
   logic [mrsi_pkg::MIN_OPS_W-1:0] min_ops;
   logic impossible;
   logic overflow;

   assign rsp_tdata = {1'b0, min_ops};
   assign rsp_tuser = {overflow, impossible};

   mrsi_ctrl #(
      .FIRST_DEPTH (FIRST_DEPTH),
      .POOL_DEPTH  (POOL_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_action     (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_min_ops    (min_ops),
      .rsp_impossible (impossible),
      .rsp_overflow   (overflow),
      .cmd            (cmd),
      .stat           (stat),
      .first_addr     (first_addr),
      .pool_waddr     (pool_waddr),
      .pool_raddr     (pool_raddr),
      .row_addr       (row_addr)
   );

   mrsi_dp #(
      .FIRST_DEPTH (FIRST_DEPTH),
      .POOL_DEPTH  (POOL_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .load_value (req_tdata[mrsi_pkg::VALUE_W-1:0]),
      .first_addr (first_addr),
      .pool_waddr (pool_waddr),
      .pool_raddr (pool_raddr),
      .row_addr   (row_addr)
   );

endmodule

`default_nettype wire
